>>> hdl/vac_pkg.sv
// vac_pkg: shared types and constants of the attribute controller
// used by vga_attribute_controller; no dependencies

package vac_pkg;

    // palette geometry
    localparam int PAL_DEPTH = 16;
    localparam int PAL_AW    = 4;
    localparam int PAL_W     = 8;

    // request kinds on the slave-side tuser
    localparam logic [1:0] REQ_WRITE    = 2'd0;
    localparam logic [1:0] REQ_RD_INDEX = 2'd1;
    localparam logic [1:0] REQ_RD_DATA  = 2'd2;

    // result kinds on the master-side tuser
    localparam logic [2:0] KIND_READ  = 3'd0;
    localparam logic [2:0] KIND_DAC   = 3'd1;
    localparam logic [2:0] KIND_BLINK = 3'd2;
    localparam logic [2:0] KIND_MODE  = 3'd3;
    localparam logic [2:0] KIND_ACK   = 3'd4;

    // register indexes above the palette
    localparam logic [4:0] IDX_MODE     = 5'h10;
    localparam logic [4:0] IDX_OVERSCAN = 5'h11;
    localparam logic [4:0] IDX_PLANE    = 5'h12;
    localparam logic [4:0] IDX_PAN      = 5'h13;
    localparam logic [4:0] IDX_COLOR    = 5'h14;

    // payload widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_WREAD = 5'b00100,
        ST_WEMIT = 5'b01000,
        ST_EVT   = 5'b10000
    } t_state;

endpackage

>>> hdl/vga_attribute_controller.sv
// vga_attribute_controller: top level of the attribute controller
// depends on vac_pkg and vac_ram (palette storage)

// One bus access is taken per item and the block is not ready until its
// last result has been loaded into the output register. A write that
// recolours the palette walks the 16 entries, each with one palette RAM
// read and then one combine and emit, and is followed by one result for
// each pending blink or mode event. The palette RAM has one registered
// read port, which sets the walk speed. The output register lets the last
// result wait for the sink while the next access is taken; stalls on the
// master side hold the sequencer.
module vga_attribute_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [vac_pkg::IN_TDATA_W-1:0] i_s_tdata,   // [7:0] wdata
    input  logic [1:0]                     i_s_tuser,   // [1:0] req_type
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [7:0] rdata, [11:8] dac_entry, [19:12] dac_color, [20] blink_on
    output logic [vac_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic [2:0]                     o_m_tuser,   // [2:0] kind
    output logic                           o_m_tlast
);

    import vac_pkg::*;

    // control and register state
    t_state                r_state, n_state;
    logic [1:0]            r_req;
    logic [7:0]            r_wdata;
    logic                  r_phase, n_phase;
    logic [4:0]            r_index, n_index;
    logic                  r_unlocked, n_unlocked;
    logic [PAL_DEPTH-1:0]  r_valid, n_valid;
    logic                  r_rvalid;
    logic [7:0]            r_mode, n_mode;
    logic [7:0]            r_overscan, n_overscan;
    logic [7:0]            r_plane, n_plane;
    logic [3:0]            r_pan, n_pan;
    logic [7:0]            r_color, n_color;
    logic [PAL_AW-1:0]     r_cnt, n_cnt;
    logic                  r_blink_pend, n_blink_pend;
    logic                  r_mode_pend, n_mode_pend;

    // output register
    logic                  r_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;
    logic [2:0]            r_m_tuser;
    logic                  r_m_tlast;

    // result load from the sequencer
    logic                  ld;
    logic [2:0]            ld_kind;
    logic [7:0]            ld_rdata;
    logic [3:0]            ld_entry;
    logic [7:0]            ld_color;
    logic                  ld_blink;
    logic                  ld_last;

    // palette ram ports
    logic                  ram_we, ram_re;
    logic [PAL_AW-1:0]     ram_raddr;
    logic [PAL_W-1:0]      ram_rdata;
    logic [PAL_W-1:0]      pal_val;

    // shared combine unit
    logic [7:0]            comb_in, comb_out;

    logic                  accept, out_free;
    logic [7:0]            diff;
    logic                  evt_pend;

    assign accept   = i_s_tvalid && (r_state == ST_IDLE);
    assign out_free = !r_m_tvalid || i_m_tready;
    assign pal_val  = r_rvalid ? ram_rdata : 8'h00;
    assign diff     = r_mode ^ r_wdata;

    // palette storage
    vac_ram #(
        .WIDTH(PAL_W),
        .DEPTH(PAL_DEPTH)
    ) u_pal (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_index[PAL_AW-1:0]),
        .i_wdata(r_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // read address: walk counter while walking, addressed entry otherwise
    assign ram_re    = accept || (r_state == ST_WREAD);
    assign ram_raddr = (r_state == ST_WREAD) ? r_cnt : r_index[PAL_AW-1:0];

    // colour combine: colour select bits 3:2 on top, bits 1:0 over the
    // palette nibble when mode bit 7 is set
    assign comb_in  = (r_state == ST_WEMIT) ? pal_val : r_wdata;
    assign comb_out = r_mode[7] ? {r_color[3:0], comb_in[3:0]}
                                : {r_color[3:2], comb_in[5:0]};

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_index      = r_index;
        n_unlocked   = r_unlocked;
        n_valid      = r_valid;
        n_mode       = r_mode;
        n_overscan   = r_overscan;
        n_plane      = r_plane;
        n_pan        = r_pan;
        n_color      = r_color;
        n_cnt        = r_cnt;
        n_blink_pend = r_blink_pend;
        n_mode_pend  = r_mode_pend;
        ram_we       = 1'b0;
        ld           = 1'b0;
        ld_kind      = KIND_ACK;
        ld_rdata     = 8'h00;
        ld_entry     = 4'h0;
        ld_color     = 8'h00;
        ld_blink     = 1'b0;
        ld_last      = 1'b1;
        evt_pend     = r_blink_pend || r_mode_pend;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                    case (r_req)
                        REQ_RD_INDEX: begin
                            ld       = 1'b1;
                            ld_kind  = KIND_READ;
                            ld_rdata = {2'b00, !r_unlocked, r_index};
                        end
                        REQ_RD_DATA: begin
                            ld      = 1'b1;
                            ld_kind = KIND_READ;
                            if (!r_index[4]) begin
                                ld_rdata = pal_val;
                            end else begin
                                case (r_index)
                                    IDX_MODE:     ld_rdata = r_mode;
                                    IDX_OVERSCAN: ld_rdata = r_overscan;
                                    IDX_PLANE:    ld_rdata = r_plane;
                                    IDX_PAN:      ld_rdata = {4'h0, r_pan};
                                    IDX_COLOR:    ld_rdata = r_color;
                                    default:      ld_rdata = 8'h00;
                                endcase
                            end
                        end
                        REQ_WRITE: begin
                            ld = 1'b1;
                            if (!r_phase) begin
                                // index phase
                                n_index    = r_wdata[4:0];
                                n_phase    = 1'b1;
                                n_unlocked = !r_wdata[5];
                            end else begin
                                // data phase
                                n_phase = 1'b0;
                                if (!r_index[4]) begin
                                    if (r_unlocked) begin
                                        ram_we   = 1'b1;
                                        n_valid[r_index[PAL_AW-1:0]] = 1'b1;
                                        ld_kind  = KIND_DAC;
                                        ld_entry = r_index[PAL_AW-1:0];
                                        ld_color = comb_out;
                                    end
                                end else begin
                                    case (r_index)
                                        IDX_MODE: begin
                                            n_mode       = r_wdata;
                                            n_blink_pend = diff[3];
                                            n_mode_pend  = diff[6] || diff[0];
                                            if (diff[7]) begin
                                                ld      = 1'b0;
                                                n_cnt   = '0;
                                                n_state = ST_WREAD;
                                            end else if (diff[3] || diff[6]
                                                         || diff[0]) begin
                                                ld      = 1'b0;
                                                n_state = ST_EVT;
                                            end
                                        end
                                        IDX_OVERSCAN: n_overscan = r_wdata;
                                        IDX_PLANE:    n_plane    = r_wdata;
                                        IDX_PAN:      n_pan      = r_wdata[3:0];
                                        IDX_COLOR: begin
                                            if (r_color != r_wdata) begin
                                                n_color      = r_wdata;
                                                n_blink_pend = 1'b0;
                                                n_mode_pend  = 1'b0;
                                                ld           = 1'b0;
                                                n_cnt        = '0;
                                                n_state      = ST_WREAD;
                                            end
                                        end
                                        default: ;
                                    endcase
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WREAD: begin
                n_state = ST_WEMIT;
            end
            ST_WEMIT: begin
                if (out_free) begin
                    ld       = 1'b1;
                    ld_kind  = KIND_DAC;
                    ld_entry = r_cnt;
                    ld_color = comb_out;
                    ld_last  = (r_cnt == PAL_AW'(PAL_DEPTH - 1)) && !evt_pend;
                    if (r_cnt == PAL_AW'(PAL_DEPTH - 1)) begin
                        n_state = evt_pend ? ST_EVT : ST_IDLE;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = ST_WREAD;
                    end
                end
            end
            ST_EVT: begin
                if (out_free) begin
                    ld = 1'b1;
                    if (r_blink_pend) begin
                        ld_kind      = KIND_BLINK;
                        ld_blink     = r_mode[3];
                        ld_last      = !r_mode_pend;
                        n_blink_pend = 1'b0;
                        if (!r_mode_pend) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        ld_kind     = KIND_MODE;
                        n_mode_pend = 1'b0;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= 1'b0;
            r_index      <= '0;
            r_unlocked   <= 1'b0;
            r_valid      <= '0;
            r_mode       <= '0;
            r_overscan   <= '0;
            r_plane      <= '0;
            r_pan        <= '0;
            r_color      <= '0;
            r_cnt        <= '0;
            r_blink_pend <= 1'b0;
            r_mode_pend  <= 1'b0;
            r_m_tvalid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_index      <= n_index;
            r_unlocked   <= n_unlocked;
            r_valid      <= n_valid;
            r_mode       <= n_mode;
            r_overscan   <= n_overscan;
            r_plane      <= n_plane;
            r_pan        <= n_pan;
            r_color      <= n_color;
            r_cnt        <= n_cnt;
            r_blink_pend <= n_blink_pend;
            r_mode_pend  <= n_mode_pend;
            r_m_tvalid   <= ld || (r_m_tvalid && !i_m_tready);
        end
    end

    // captured item and read-side valid bit
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_s_tuser;
            r_wdata <= i_s_tdata;
        end
        if (ram_re) begin
            r_rvalid <= r_valid[ram_raddr];
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_m_tdata <= {3'b000, ld_blink, ld_color, ld_entry, ld_rdata};
            r_m_tuser <= ld_kind;
            r_m_tlast <= ld_last;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;
    assign o_m_tlast  = r_m_tlast;

endmodule

>>> hdl/vac_ram.sv
// vac_ram: generic single-write, single-read RAM with registered read
// no dependencies

module vac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
